@@ hw/rtl/twm_pkg.sv @@
package twm_pkg;

  localparam int DEF_WINDOW_DEPTH = 10;
  localparam int DEF_SAMPLE_BITS  = 16;
  localparam int QUEUE_DEPTH      = 2;

  localparam int FIELD_W     = 16;
  localparam int FILL_OUT_W  = 4;
  localparam int UNIT_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int THRESH_W    = 15;
  localparam int OUT_TDATA_W = 56;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_TREND_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELSIUS_LOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELSIUS_HIGH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAHRENHEIT_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAHRENHEIT_HIGH = 3'd4;

  localparam logic [THRESH_W-1:0]   RST_TREND_THRESHOLD = 15'd5;
  localparam logic [CFG_DATA_W-1:0] RST_CELSIUS_LOW     = 16'sd3550;
  localparam logic [CFG_DATA_W-1:0] RST_CELSIUS_HIGH    = 16'sd3750;
  localparam logic [CFG_DATA_W-1:0] RST_FAHRENHEIT_LOW  = 16'sd9590;
  localparam logic [CFG_DATA_W-1:0] RST_FAHRENHEIT_HIGH = 16'sd9950;

  localparam logic [UNIT_W-1:0] UNIT_CELSIUS    = 2'd0;
  localparam logic [UNIT_W-1:0] UNIT_FAHRENHEIT = 2'd1;

  typedef enum logic [1:0] {
    TREND_STABLE  = 2'd0,
    TREND_RISING  = 2'd1,
    TREND_FALLING = 2'd2
  } trend_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ACCUM,
    B_DIV
  } back_state_t;

  typedef struct packed {
    logic [THRESH_W-1:0]          trend_threshold;
    logic signed [CFG_DATA_W-1:0] celsius_low_limit;
    logic signed [CFG_DATA_W-1:0] celsius_high_limit;
    logic signed [CFG_DATA_W-1:0] fahrenheit_low_limit;
    logic signed [CFG_DATA_W-1:0] fahrenheit_high_limit;
  } cfg_t;

  // per-item results settled in the front part
  typedef struct packed {
    logic [FIELD_W-1:0] running_minimum;
    logic [FIELD_W-1:0] running_maximum;
    trend_t             trend_code;
    logic               out_of_range;
  } info_t;

endpackage

@@ hw/rtl/twm_front.sv @@
module twm_front #(
  parameter int SAMPLE_BITS = twm_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  twm_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic [twm_pkg::UNIT_W-1:0]    in_unit,
  output logic                          push_valid,
  input  logic                          push_ready,
  output logic signed [SAMPLE_BITS-1:0] push_sample,
  output twm_pkg::info_t                push_info
);

  localparam int CMP_W = (SAMPLE_BITS > twm_pkg::CFG_DATA_W) ? SAMPLE_BITS
                                                             : twm_pkg::CFG_DATA_W;
  localparam int DIF_W = ((SAMPLE_BITS + 1 > twm_pkg::CFG_DATA_W) ? SAMPLE_BITS + 1
                                                                  : twm_pkg::CFG_DATA_W) + 1;

  logic signed [SAMPLE_BITS-1:0] prev_r, min_r, max_r, min_nxt, max_nxt;
  logic                          seen_r;
  logic signed [DIF_W-1:0]       diff, thr, thr_neg;
  logic signed [CMP_W-1:0]       s_x, lo_x, hi_x;
  logic                          accept;
  twm_pkg::trend_t               trend;
  logic                          flag;

  assign in_ready    = push_ready;
  assign push_valid  = in_valid;
  assign accept      = in_valid && push_ready;
  assign push_sample = in_sample;

  always_comb begin
    diff    = DIF_W'(in_sample) - DIF_W'(prev_r);
    thr     = $signed(DIF_W'(cfg.trend_threshold));
    thr_neg = -thr;
    trend   = twm_pkg::TREND_STABLE;
    if (seen_r) begin
      if (diff > thr) begin
        trend = twm_pkg::TREND_RISING;
      end else if (diff < thr_neg) begin
        trend = twm_pkg::TREND_FALLING;
      end
    end

    s_x = CMP_W'(in_sample);
    case (in_unit)
      twm_pkg::UNIT_CELSIUS: begin
        lo_x = CMP_W'(cfg.celsius_low_limit);
        hi_x = CMP_W'(cfg.celsius_high_limit);
        flag = (s_x < lo_x) || (s_x > hi_x);
      end
      twm_pkg::UNIT_FAHRENHEIT: begin
        lo_x = CMP_W'(cfg.fahrenheit_low_limit);
        hi_x = CMP_W'(cfg.fahrenheit_high_limit);
        flag = (s_x < lo_x) || (s_x > hi_x);
      end
      default: begin
        lo_x = '0;
        hi_x = '0;
        flag = 1'b0;
      end
    endcase

    min_nxt = (in_sample < min_r) ? in_sample : min_r;
    max_nxt = (in_sample > max_r) ? in_sample : max_r;

    push_info.running_minimum = twm_pkg::FIELD_W'(min_nxt);
    push_info.running_maximum = twm_pkg::FIELD_W'(max_nxt);
    push_info.trend_code      = trend;
    push_info.out_of_range    = flag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      prev_r <= '0;
      min_r  <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      max_r  <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else if (accept) begin
      seen_r <= 1'b1;
      prev_r <= in_sample;
      min_r  <= min_nxt;
      max_r  <= max_nxt;
    end
  end

endmodule

@@ hw/rtl/twm_queue.sv @@
module twm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = twm_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ hw/rtl/twm_div.sv @@
module twm_div #(
  parameter int DIVIDEND_W = 20,
  parameter int DIVISOR_W  = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]         divisor,
  output logic                         done,
  output logic signed [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, done_r, neg_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVIDEND_W-1:0] q_r;
  logic [DIVISOR_W:0]    rem_r, shifted, rem_nxt;
  logic [DIVISOR_W-1:0]  dvs_r;
  logic                  fits;

  // restoring divide on the magnitude, one quotient bit per cycle
  always_comb begin
    shifted = {rem_r[DIVISOR_W-1:0], q_r[DIVIDEND_W-1]};
    fits    = (shifted >= {1'b0, dvs_r});
    rem_nxt = fits ? (shifted - {1'b0, dvs_r}) : shifted;
  end

  assign done     = done_r;
  assign quotient = neg_r ? $signed('0 - q_r) : $signed(q_r);

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[DIVIDEND_W-1];
      q_r   <= dividend[DIVIDEND_W-1] ? ('0 - dividend) : dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DIVIDEND_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DIVIDEND_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/twm_back.sv @@
module twm_back #(
  parameter int WINDOW_DEPTH = twm_pkg::DEF_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = twm_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                pop_valid,
  output logic                                pop_ready,
  input  logic signed [SAMPLE_BITS-1:0]       pop_sample,
  input  twm_pkg::info_t                      pop_info,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [twm_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_BITS + FILL_W;
  localparam int PAD_W  = twm_pkg::OUT_TDATA_W - 3 * twm_pkg::FIELD_W
                          - $bits(twm_pkg::trend_t) - 1 - twm_pkg::FILL_OUT_W;

  twm_pkg::back_state_t          state_r, state_nxt;
  logic signed [SAMPLE_BITS-1:0] window_mem [WINDOW_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_r, samp_r;
  twm_pkg::info_t                info_r;
  logic [SLOT_W-1:0]             slot_r, slot_nxt;
  logic [FILL_W-1:0]             fill_r, fill_nxt;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt, leaving;
  logic                          full, div_start, div_done, out_load;
  logic signed [SUM_W-1:0]       quot;
  logic                          out_valid_r;
  logic [twm_pkg::OUT_TDATA_W-1:0] out_data_r;

  twm_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (FILL_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (fill_nxt),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    full     = (fill_r == FILL_W'(WINDOW_DEPTH));
    leaving  = full ? SUM_W'(rd_r) : '0;
    sum_nxt  = sum_r - leaving + SUM_W'(samp_r);
    fill_nxt = full ? fill_r : fill_r + 1'b1;
    slot_nxt = (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;

    pop_ready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      twm_pkg::B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_nxt = twm_pkg::B_ACCUM;
        end
      end
      twm_pkg::B_ACCUM: begin
        div_start = 1'b1;
        state_nxt = twm_pkg::B_DIV;
      end
      twm_pkg::B_DIV: begin
        if (div_done && (!out_valid_r || out_tready)) begin
          out_load  = 1'b1;
          state_nxt = twm_pkg::B_IDLE;
        end
      end
      default: state_nxt = twm_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= twm_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // window store: oldest sample registered in the cycle before the overwrite
  always_ff @(posedge clk) begin
    if (state_r == twm_pkg::B_ACCUM) begin
      window_mem[slot_r] <= samp_r;
    end
    rd_r <= window_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      samp_r <= pop_sample;
      info_r <= pop_info;
    end
    if (out_load) begin
      out_data_r <= {{PAD_W{1'b0}},
                     twm_pkg::FILL_OUT_W'(fill_r),
                     info_r.out_of_range,
                     info_r.trend_code,
                     info_r.running_maximum,
                     info_r.running_minimum,
                     twm_pkg::FIELD_W'(quot)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == twm_pkg::B_ACCUM) begin
        slot_r <= slot_nxt;
        fill_r <= fill_nxt;
        sum_r  <= sum_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ hw/rtl/temperature_window_monitor_unit.sv @@
// Temperature window monitor: one result beat per sample beat.
// Input stream: in_tdata carries a signed sample in hundredths of a degree,
// in_tuser its unit (Celsius, Fahrenheit, anything else is unknown).
// Output stream: window average, all-time min and max, trend versus the
// previous sample, out-of-range flag against the unit's limits, window fill.
// Config port: cfg_index picks the register (threshold, then the four
// limits), cfg_data the value; always ready, meant to be used while idle.
// The front checks trend, limits and min/max as a beat is taken and pushes
// it into a two-entry queue; the back updates the sample ring and the sum,
// then divides the sum by the fill count one quotient bit per cycle.
// The back takes no new sample until the bit-serial divider has finished and
// its result is loaded into the output register. The front keeps taking
// beats until the queue is full.
// A stalled receiver holds the result register; the back then waits with the
// next quotient ready, and in_tready drops once the queue fills.
// Reset (rst_n low, synchronous) empties window, sum, queue and output and
// reloads the limit registers with their defaults.
module temperature_window_monitor_unit #(
  parameter int WINDOW_DEPTH = twm_pkg::DEF_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = twm_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // in_tdata: [SAMPLE_BITS-1:0] sample_value, upper bits zero
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // in_tuser: [1:0] unit_code
  input  logic [twm_pkg::UNIT_W-1:0]             in_tuser,
  // out_tdata: [15:0] window_average, [31:16] running_minimum,
  // [47:32] running_maximum, [49:48] trend_code, [50] out_of_range,
  // [54:51] window_fill, [55] zero
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [twm_pkg::OUT_TDATA_W-1:0]        out_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [twm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [twm_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int Q_W = SAMPLE_BITS + $bits(twm_pkg::info_t);

  twm_pkg::cfg_t                 cfg_r;
  logic                          q_push_valid, q_push_ready;
  logic                          q_pop_valid, q_pop_ready;
  logic signed [SAMPLE_BITS-1:0] f_sample, b_sample;
  twm_pkg::info_t                f_info, b_info;
  logic [Q_W-1:0]                q_pop_data;

  assign cfg_ready = 1'b1;

  // limit and threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trend_threshold       <= twm_pkg::RST_TREND_THRESHOLD;
      cfg_r.celsius_low_limit     <= twm_pkg::RST_CELSIUS_LOW;
      cfg_r.celsius_high_limit    <= twm_pkg::RST_CELSIUS_HIGH;
      cfg_r.fahrenheit_low_limit  <= twm_pkg::RST_FAHRENHEIT_LOW;
      cfg_r.fahrenheit_high_limit <= twm_pkg::RST_FAHRENHEIT_HIGH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        twm_pkg::REG_TREND_THRESHOLD:
          cfg_r.trend_threshold <= cfg_data[twm_pkg::THRESH_W-1:0];
        twm_pkg::REG_CELSIUS_LOW:     cfg_r.celsius_low_limit     <= cfg_data;
        twm_pkg::REG_CELSIUS_HIGH:    cfg_r.celsius_high_limit    <= cfg_data;
        twm_pkg::REG_FAHRENHEIT_LOW:  cfg_r.fahrenheit_low_limit  <= cfg_data;
        twm_pkg::REG_FAHRENHEIT_HIGH: cfg_r.fahrenheit_high_limit <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  twm_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_sample   ($signed(in_tdata[SAMPLE_BITS-1:0])),
    .in_unit     (in_tuser),
    .push_valid  (q_push_valid),
    .push_ready  (q_push_ready),
    .push_sample (f_sample),
    .push_info   (f_info)
  );

  twm_queue #(
    .WIDTH (Q_W),
    .DEPTH (twm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  ({f_sample, f_info}),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  assign b_sample = $signed(q_pop_data[Q_W-1 -: SAMPLE_BITS]);
  assign b_info   = q_pop_data[$bits(twm_pkg::info_t)-1:0];

  twm_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_sample (b_sample),
    .pop_info   (b_info),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef NO_ASSERTIONS
  // every result follows at least one sample, so min never exceeds max
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (SAMPLE_BITS > twm_pkg::FIELD_W) ||
                   ($signed(out_tdata[31:16]) <= $signed(out_tdata[47:32])))
    else $error("running minimum above running maximum");

  // a fill of one only comes with the first sample, which has no trend
  a_first_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[54:51] == 4'd1)) |->
      (WINDOW_DEPTH > 15) || (out_tdata[49:48] == twm_pkg::TREND_STABLE))
    else $error("trend reported on first sample");

  // the front only pushes what it was handed on an accepted beat
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push_valid && q_push_ready) |-> (in_tvalid && in_tready &&
      (f_sample == $signed(in_tdata[SAMPLE_BITS-1:0]))))
    else $error("queue push without matching input beat");
`endif

endmodule
